// File: design/awns_pkg.sv
// Shared types and constants for the weekly alarm table search block.
package awns_pkg;

   // request kinds
   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_APPEND = 3'd1;
   localparam logic [2:0] REQ_FIND   = 3'd2;
   localparam logic [2:0] REQ_DUE    = 3'd3;
   localparam logic [2:0] REQ_QUERY  = 3'd4;

   // configuration register map
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_WEEKEND_OFF = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_AUTH   = 8'd1;

   localparam logic [7:0] HOUR_LIMIT   = 8'd24;
   localparam logic [7:0] MINUTE_LIMIT = 8'd60;
   localparam logic [7:0] NONE_BYTE    = 8'hFF;
   localparam logic [2:0] LAST_WORKDAY = 3'd4;

   localparam int ENTRIES_W = 6;
   localparam int SHOWN_W   = 5;

   typedef struct packed {
      logic [7:0] days;
      logic [7:0] hour;
      logic [7:0] minute;
   } alarm_entry_type;

   typedef struct packed {
      logic day_hit;
      logic time_ok;
      logic later;
   } cmp_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_FIND,
      ST_TALLY,
      ST_PICK,
      ST_EMIT
   } seq_state_type;

endpackage

// File: design/awns_table.sv
// Alarm entry storage: one write port, one registered read port.
module awns_table #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  awns_pkg::alarm_entry_type wr_data,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output awns_pkg::alarm_entry_type rd_data
);
   import awns_pkg::*;

   alarm_entry_type mem [DEPTH];
   alarm_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/awns_cmp.sv
// Shared compare unit: weekday hit, time sanity and 16-bit later-than test.
module awns_cmp (
   input  logic [7:0]               days,
   input  logic [2:0]               day,
   input  logic [7:0]               lhs_hour,
   input  logic [7:0]               lhs_minute,
   input  logic [15:0]              rhs_time,
   output awns_pkg::cmp_result_type result
);
   import awns_pkg::*;

   always_comb begin
      result.day_hit = days[day];
      result.time_ok = (lhs_hour < HOUR_LIMIT) && (lhs_minute < MINUTE_LIMIT);
      // hour:minute compared as one word
      result.later   = {lhs_hour, lhs_minute} > rhs_time;
   end

endmodule

// File: design/weekly_alarm_table_next_search_core.sv
// Weekly alarm table with next-alarm search: sequencer, state and result register.
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------------
//  req     | req_valid / req_ready + fields | one request (clear, append, ...)
//  rsp     | rsp_valid / rsp_ready + fields | one result per request
//  csr     | csr_valid / csr_ready, index   | one register write, always ready
//
// Clear, append, due check, unused kinds and a blocked find pass from start straight to emit.
// Find next walks the table one entry per cycle, up to the count of stored entries.
// Query walks twice (tally, then pick); the pick pass is skipped when no entry is for today.
// The single read port of the table sets the walk rate.
// Reset clears count, pending alarm, configuration registers and result valid; table contents stay undefined.
// A held result stalls only the final step; the next request is taken once idle.
module weekly_alarm_table_next_search_core #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_type,
   input  logic [7:0]                      req_entry_days,
   input  logic [7:0]                      req_entry_hour,
   input  logic [7:0]                      req_entry_minute,
   input  logic [2:0]                      req_day_of_week,
   input  logic [4:0]                      req_now_hour,
   input  logic [5:0]                      req_now_minute,
   input  logic [7:0]                      req_query_index,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_next_valid,
   output logic [4:0]                      rsp_next_hour,
   output logic [5:0]                      rsp_next_minute,
   output logic [7:0]                      rsp_show_hour,
   output logic [7:0]                      rsp_show_minute,
   output logic                            rsp_due,
   output logic [awns_pkg::SHOWN_W-1:0]    rsp_shown_index,
   output logic [awns_pkg::ENTRIES_W-1:0]  rsp_entries_stored,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [awns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [awns_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import awns_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

   seq_state_type state_ff, state_in;

   // configuration registers
   logic weekend_off_ff, link_auth_ff;

   // captured request
   logic [2:0]      cmd_ff;
   alarm_entry_type entry_ff;
   logic [2:0]      day_ff;
   logic [4:0]      now_hour_ff;
   logic [5:0]      now_minute_ff;
   logic [7:0]      qidx_ff;

   // architectural state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [4:0]       pend_hour_ff, pend_hour_in;
   logic [5:0]       pend_minute_ff, pend_minute_in;

   // working result
   logic [7:0]         show_hour_ff, show_hour_in;
   logic [7:0]         show_minute_ff, show_minute_in;
   logic               due_ff, due_in;
   logic [SHOWN_W-1:0] shown_ff, shown_in;

   // walk control
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             first_ff, first_in;
   logic [CNT_W-1:0] tally_ff, tally_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] sel_ff, sel_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_next_valid_ff;
   logic [4:0]           rsp_next_hour_ff;
   logic [5:0]           rsp_next_minute_ff;
   logic [7:0]           rsp_show_hour_ff, rsp_show_minute_ff;
   logic                 rsp_due_ff;
   logic [SHOWN_W-1:0]   rsp_shown_ff;
   logic [ENTRIES_W-1:0] rsp_entries_ff;

   // table and compare unit
   logic            wr_en, rd_en;
   alarm_entry_type rd_data;
   cmp_result_type  cmp;
   logic [7:0]      cmp_hour, cmp_minute;

   logic walking, more, stop, issue, pass_end, slot_free, find_blocked;
   logic hit, found_now, emit_load;
   logic [CMP_W-1:0] qidx_wide, tally_wide;

   awns_table #(
      .DEPTH (MAX_ENTRIES),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (entry_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // due check borrows the unit with the pending time on the left side
   assign cmp_hour   = (state_ff == ST_START) ? {3'b000, pend_hour_ff}  : rd_data.hour;
   assign cmp_minute = (state_ff == ST_START) ? {2'b00, pend_minute_ff} : rd_data.minute;

   awns_cmp u_cmp (
      .days       (rd_data.days),
      .day        (day_ff),
      .lhs_hour   (cmp_hour),
      .lhs_minute (cmp_minute),
      .rhs_time   ({3'b000, now_hour_ff, 2'b00, now_minute_ff}),
      .result     (cmp)
   );

   assign walking      = (state_ff == ST_FIND) || (state_ff == ST_TALLY) ||
                         (state_ff == ST_PICK);
   assign more         = rd_idx_ff < count_ff;
   assign hit          = rd_vld_ff && cmp.day_hit;
   assign found_now    = hit && cmp.time_ok && cmp.later;
   // find stops at an impossible time or at the first later alarm today;
   // pick stops at the selected entry of today
   assign stop         = rd_vld_ff &&
                         (((state_ff == ST_FIND) &&
                           (!cmp.time_ok || (cmp.day_hit && cmp.later))) ||
                          ((state_ff == ST_PICK) && cmp.day_hit && (pos_ff == sel_ff)));
   assign issue        = walking && more && !stop;
   assign pass_end     = walking && (stop || (!rd_vld_ff && !more));
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign emit_load    = (state_ff == ST_EMIT) && slot_free;
   assign find_blocked = !link_auth_ff || (weekend_off_ff && (day_ff > LAST_WORKDAY));
   assign qidx_wide    = CMP_W'(qidx_ff);
   assign tally_wide   = CMP_W'(tally_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            if ((cmd_ff == REQ_FIND) && !find_blocked) state_in = ST_FIND;
            else if (cmd_ff == REQ_QUERY)               state_in = ST_TALLY;
            else                                        state_in = ST_EMIT;
         end
         ST_FIND: begin
            if (pass_end) state_in = ST_EMIT;
         end
         ST_TALLY: begin
            if (pass_end) state_in = (tally_ff == '0) ? ST_EMIT : ST_PICK;
         end
         ST_PICK: begin
            if (pass_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls and next values
   always_comb begin
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      count_in       = count_ff;
      pend_valid_in  = pend_valid_ff;
      pend_hour_in   = pend_hour_ff;
      pend_minute_in = pend_minute_ff;
      show_hour_in   = show_hour_ff;
      show_minute_in = show_minute_ff;
      due_in         = due_ff;
      shown_in       = shown_ff;
      rd_idx_in      = rd_idx_ff;
      rd_vld_in      = 1'b0;
      first_in       = first_ff;
      tally_in       = tally_ff;
      pos_in         = pos_ff;
      sel_in         = sel_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (walking) begin
         rd_en     = issue;
         rd_vld_in = issue;
         if (issue) rd_idx_in = rd_idx_ff + CNT_ONE;
      end

      unique case (state_ff)
         ST_START: begin
            show_hour_in   = NONE_BYTE;
            show_minute_in = NONE_BYTE;
            due_in         = 1'b0;
            shown_in       = '0;
            rd_idx_in      = '0;
            first_in       = 1'b0;
            tally_in       = '0;
            pos_in         = '0;
            unique case (cmd_ff)
               REQ_CLEAR: begin
                  count_in = '0;
               end
               REQ_APPEND: begin
                  if (count_ff < FULL_COUNT) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_ONE;
                  end
               end
               REQ_FIND: begin
                  if (find_blocked) begin
                     pend_valid_in  = 1'b0;
                     pend_hour_in   = '0;
                     pend_minute_in = '0;
                  end
               end
               REQ_DUE: begin
                  // due when now >= pending, i.e. pending is not later
                  due_in = pend_valid_ff && !cmp.later;
               end
               default: begin
               end
            endcase
         end
         ST_FIND: begin
            if (hit && cmp.time_ok) begin
               if (!first_ff) begin
                  first_in       = 1'b1;
                  show_hour_in   = rd_data.hour;
                  show_minute_in = rd_data.minute;
               end
               if (cmp.later) begin
                  pend_valid_in  = 1'b1;
                  pend_hour_in   = rd_data.hour[4:0];
                  pend_minute_in = rd_data.minute[5:0];
               end
            end
            if (pass_end && !found_now) begin
               pend_valid_in  = 1'b0;
               pend_hour_in   = '0;
               pend_minute_in = '0;
            end
         end
         ST_TALLY: begin
            if (hit) tally_in = tally_ff + CNT_ONE;
            if (pass_end) begin
               rd_idx_in = '0;
               pos_in    = '0;
               sel_in    = (qidx_wide >= tally_wide) ? '0 : qidx_wide[CNT_W-1:0];
            end
         end
         ST_PICK: begin
            if (hit) begin
               if (pos_ff == sel_ff) begin
                  if (cmp.time_ok) begin
                     show_hour_in   = rd_data.hour;
                     show_minute_in = rd_data.minute;
                     shown_in       = SHOWN_W'(sel_ff);
                  end
               end else begin
                  pos_in = pos_ff + CNT_ONE;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         weekend_off_ff <= 1'b0;
         link_auth_ff   <= 1'b0;
         count_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         pend_hour_ff   <= '0;
         pend_minute_ff <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         pend_valid_ff  <= pend_valid_in;
         pend_hour_ff   <= pend_hour_in;
         pend_minute_ff <= pend_minute_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WEEKEND_OFF) weekend_off_ff <= csr_wdata[0];
            if (csr_index == CSR_LINK_AUTH)   link_auth_ff   <= csr_wdata[0];
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff        <= req_type;
         entry_ff      <= '{days: req_entry_days, hour: req_entry_hour,
                            minute: req_entry_minute};
         day_ff        <= req_day_of_week;
         now_hour_ff   <= req_now_hour;
         now_minute_ff <= req_now_minute;
         qidx_ff       <= req_query_index;
      end
      show_hour_ff   <= show_hour_in;
      show_minute_ff <= show_minute_in;
      due_ff         <= due_in;
      shown_ff       <= shown_in;
      rd_idx_ff      <= rd_idx_in;
      first_ff       <= first_in;
      tally_ff       <= tally_in;
      pos_ff         <= pos_in;
      sel_ff         <= sel_in;
      if (emit_load) begin
         rsp_next_valid_ff  <= pend_valid_ff;
         rsp_next_hour_ff   <= pend_hour_ff;
         rsp_next_minute_ff <= pend_minute_ff;
         rsp_show_hour_ff   <= show_hour_ff;
         rsp_show_minute_ff <= show_minute_ff;
         rsp_due_ff         <= due_ff;
         rsp_shown_ff       <= shown_ff;
         rsp_entries_ff     <= ENTRIES_W'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_valid     = rsp_next_valid_ff;
   assign rsp_next_hour      = rsp_next_hour_ff;
   assign rsp_next_minute    = rsp_next_minute_ff;
   assign rsp_show_hour      = rsp_show_hour_ff;
   assign rsp_show_minute    = rsp_show_minute_ff;
   assign rsp_due            = rsp_due_ff;
   assign rsp_shown_index    = rsp_shown_ff;
   assign rsp_entries_stored = rsp_entries_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count past table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_idx_ff < count_ff))
      else $error("table read beyond stored entries");

   a_pending_clean: assert property (@(posedge clock) disable iff (reset)
      !pend_valid_ff |-> ((pend_hour_ff == '0) && (pend_minute_ff == '0)))
      else $error("invalid pending alarm carries a time");

   a_emit_beat: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("result load did not raise rsp_valid");

endmodule
